### rtl/ipru_pkg.sv
// ----------------------------------------------------------------------------
// ipru_pkg
// Shared types and constants for the integer pixel replicate upscaler.
// ----------------------------------------------------------------------------
package ipru_pkg;

  // default sizing
  localparam int DEF_MAX_WIDTH = 1024;
  localparam int DEF_MAX_SCALE = 64;

  // field widths
  localparam int PIX_W      = 24;
  localparam int SCALE_W    = 7;
  localparam int SRC_W_W    = 11;
  localparam int PAD_W      = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 11;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SCALE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH = 1'b1;

  // input operation codes
  localparam logic OP_PIXEL  = 1'b0;
  localparam logic OP_REPLAY = 1'b1;

  // one run of copies handed from the front end to the back end
  typedef struct packed {
    logic [PIX_W-1:0]   pix;
    logic [SCALE_W-1:0] count;     // copies to emit, 1..MAX_SCALE
    logic               row_last;  // run closes an output row
    logic [PAD_W-1:0]   pad;
  } cmd_t;

endpackage

### rtl/ipru_front.sv
// ----------------------------------------------------------------------------
// ipru_front
// Accepts pixels and replay ticks, holds configuration, line buffer and row
// position, and turns each item that produces output into one run command.
// ----------------------------------------------------------------------------
module ipru_front import ipru_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH,
  parameter int MAX_SCALE = DEF_MAX_SCALE
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  operation,
  input  logic [PIX_W-1:0]      pixel,
  output logic                  push_valid,
  input  logic                  push_ready,
  output cmd_t                  push_cmd
);

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int RW = (MAX_SCALE > 1) ? $clog2(MAX_SCALE) : 1;

  logic [SCALE_W-1:0] scale;
  logic [SRC_W_W-1:0] source_width;
  logic [CW-1:0]      column;
  logic [RW-1:0]      rows_to_replay;

  logic [PIX_W-1:0]   line_store [MAX_WIDTH];
  logic [PIX_W-1:0]   rd_data;

  logic               s1_valid;
  logic               s1_from_mem;
  cmd_t               s1_cmd;

  logic [SCALE_W-1:0] eff_n;
  logic [WW-1:0]      eff_w;
  logic [PAD_W-1:0]   w_lo;
  logic [PAD_W-1:0]   n_lo;
  logic [PAD_W-1:0]   pad;
  logic               last_col;
  logic               replaying;
  logic               emit;
  logic               accept;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      scale        <= SCALE_W'(1);
      source_width <= SRC_W_W'(1);
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_SCALE: scale        <= cfg_data[SCALE_W-1:0];
        REG_WIDTH: source_width <= cfg_data[SRC_W_W-1:0];
      endcase
    end
  end

  // clamp configuration into its legal range
  always_comb begin
    if (scale == '0) begin
      eff_n = SCALE_W'(1);
    end else if (32'(scale) > MAX_SCALE) begin
      eff_n = SCALE_W'(MAX_SCALE);
    end else begin
      eff_n = scale;
    end
    if (source_width == '0) begin
      eff_w = WW'(1);
    end else if (32'(source_width) > MAX_WIDTH) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(source_width);
    end
  end

  // row padding: (4 - 3*w*n mod 4) mod 4 equals w*n mod 4
  assign w_lo = PAD_W'(32'(eff_w));
  assign n_lo = PAD_W'(32'(eff_n));
  assign pad  = PAD_W'(w_lo * n_lo);

  // classify the incoming item
  assign last_col  = (32'(column) + 32'd1) >= 32'(eff_w);
  assign replaying = (rows_to_replay != '0);
  assign emit      = (operation == OP_PIXEL) ? !replaying : replaying;
  assign in_ready  = !s1_valid || push_ready;
  assign accept    = in_valid && in_ready;

  // row position and owed replay rows
  always_ff @(posedge clk) begin
    if (rst) begin
      column         <= '0;
      rows_to_replay <= '0;
    end else if (accept && emit) begin
      if (last_col) begin
        column <= '0;
        if (operation == OP_PIXEL) begin
          rows_to_replay <= RW'(eff_n - SCALE_W'(1));
        end else begin
          rows_to_replay <= rows_to_replay - RW'(1);
        end
      end else begin
        column <= column + CW'(1);
      end
    end
  end

  // line buffer, registered read for replays
  always_ff @(posedge clk) begin
    if (accept && emit && operation == OP_PIXEL) begin
      line_store[column] <= pixel;
    end
    if (accept && operation == OP_REPLAY) begin
      rd_data <= line_store[column];
    end
  end

  // command stage ahead of the queue
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= accept && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_from_mem     <= (operation == OP_REPLAY);
      s1_cmd.pix      <= pixel;
      s1_cmd.count    <= eff_n;
      s1_cmd.row_last <= last_col;
      s1_cmd.pad      <= pad;
    end
  end

  // hand the run to the queue, pixel from the buffer on replays
  always_comb begin
    push_cmd = s1_cmd;
    if (s1_from_mem) begin
      push_cmd.pix = rd_data;
    end
  end
  assign push_valid = s1_valid;

endmodule

### rtl/ipru_queue.sv
// ----------------------------------------------------------------------------
// ipru_queue
// Two-entry command queue between the front end and the back end.
// ----------------------------------------------------------------------------
module ipru_queue import ipru_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  cmd_t push_cmd,
  output logic head_valid,
  input  logic pop,
  output cmd_t head
);

  cmd_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       do_push;
  logic       do_pop;

  assign push_ready = (fill != 2'd2);
  assign head_valid = (fill != 2'd0);
  assign head       = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && head_valid;

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 2'd1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 2'd1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

endmodule

### rtl/ipru_back.sv
// ----------------------------------------------------------------------------
// ipru_back
// Expands each run command into its copies, one output pixel per cycle while
// the receiver is ready, through a registered output stage.
// ----------------------------------------------------------------------------
module ipru_back import ipru_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             head_valid,
  input  cmd_t             head,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [PIX_W-1:0] out_pixel,
  output logic             row_end,
  output logic [PAD_W-1:0] pad_bytes,
  output logic             run_last
);

  logic               busy;
  cmd_t               cur;
  logic [SCALE_W-1:0] left;
  logic               advance;
  logic               src_valid;
  cmd_t               src;
  logic [SCALE_W-1:0] src_left;
  logic               src_last;

  // current run or the queue head when no run is open
  assign advance   = !out_valid || out_ready;
  assign src_valid = busy || head_valid;
  assign src       = busy ? cur : head;
  assign src_left  = busy ? left : head.count;
  assign src_last  = (src_left <= SCALE_W'(1));
  assign pop       = advance && !busy && head_valid;

  // run tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (advance && src_valid) begin
      busy <= !src_last;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && src_valid) begin
      cur  <= src;
      left <= src_left - SCALE_W'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= src_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && src_valid) begin
      out_pixel <= src.pix;
      row_end   <= src_last && src.row_last;
      pad_bytes <= (src_last && src.row_last) ? src.pad : '0;
      run_last  <= src_last;
    end
  end

endmodule

### rtl/integer_pixel_replicate_upscale_top.sv
// ----------------------------------------------------------------------------
// integer_pixel_replicate_upscale_top
// Nearest-neighbor integer upscaler for a stream of 24-bit pixels.
// ----------------------------------------------------------------------------
// Usage:
//   Configuration: cfg_write with cfg_index 0 sets scale, 1 sets source_width;
//   change it only while the block is idle.
//   Input channel (in_valid/in_ready): operation 0 carries a source pixel,
//   operation 1 is a replay tick that re-emits one buffered pixel. A pixel
//   arriving while replay rows are owed, and a tick with none owed, are
//   accepted and produce nothing.
//   Output channel (out_valid/out_ready): each productive item gives scale
//   copies; run_last marks the last copy, row_end the last pixel of an output
//   row, with pad_bytes the row's padding.
//   Path: an item's run passes the command stage, run queue and output register.
//   Throughput: the back end emits one copy per cycle while out_ready allows,
//   scale copies (1..64) per item; the front end takes one item per cycle
//   while the two-entry run queue has room.
//   Reset clears configuration to scale 1 and width 1, row position and owed
//   rows; the line buffer is not cleared. A stalled receiver holds the output
//   register, then fills the queue, then drops in_ready.
// ----------------------------------------------------------------------------
module integer_pixel_replicate_upscale_top import ipru_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH,
  parameter int MAX_SCALE = DEF_MAX_SCALE
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  operation,
  input  logic [PIX_W-1:0]      pixel,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [PIX_W-1:0]      out_pixel,
  output logic                  row_end,
  output logic [PAD_W-1:0]      pad_bytes,
  output logic                  run_last
);

  logic push_valid;
  logic push_ready;
  cmd_t push_cmd;
  logic head_valid;
  logic pop;
  cmd_t head;

  // front end: classify items, line buffer, row state
  ipru_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_SCALE (MAX_SCALE)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .operation  (operation),
    .pixel      (pixel),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  // run queue
  ipru_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .head_valid (head_valid),
    .pop        (pop),
    .head       (head)
  );

  // back end: copy expansion and output register
  ipru_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_pixel  (out_pixel),
    .row_end    (row_end),
    .pad_bytes  (pad_bytes),
    .run_last   (run_last)
  );

endmodule

### rtl/ipru_checker.sv
// ----------------------------------------------------------------------------
// ipru_checker
// Port-level checks for the upscaler, bound to the top level.
// ----------------------------------------------------------------------------
module ipru_checker import ipru_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             out_valid,
  input logic             out_ready,
  input logic [PIX_W-1:0] out_pixel,
  input logic             row_end,
  input logic [PAD_W-1:0] pad_bytes,
  input logic             run_last
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_pixel) && $stable(run_last))
    else $error("output changed while stalled");

  // a row always closes a run
  a_row_end_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && row_end |-> run_last)
    else $error("row end inside a run");

  // padding only shown at a row end
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !row_end |-> pad_bytes == '0)
    else $error("padding outside a row end");

  // reset empties the output stage
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind integer_pixel_replicate_upscale_top ipru_checker u_ipru_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_pixel (out_pixel),
  .row_end   (row_end),
  .pad_bytes (pad_bytes),
  .run_last  (run_last)
);
